// ----- design/mvm_pkg.sv -----
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int unsigned ROWS_DEF = 16;
  localparam int unsigned COLS_DEF = 64;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned ROW_W    = 4;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned IDX_W    = 7;

  typedef enum logic {
    CMD_WEIGHT  = 1'b0,
    CMD_ELEMENT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic wr;
    logic mac;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- design/mvm_cell.sv -----
`timescale 1ns / 1ps

module mvm_cell #(
  parameter int unsigned COLS = 64,
  parameter int unsigned CW   = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mvm_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CW-1:0]                     wr_col_i,
  input  logic [CW-1:0]                     rd_col_i,
  input  logic signed [mvm_pkg::VAL_W-1:0]  wr_data_i,
  input  logic signed [mvm_pkg::VAL_W-1:0]  x_i,
  input  logic signed [mvm_pkg::SUM_W-1:0]  sh_i,
  output logic signed [mvm_pkg::SUM_W-1:0]  sh_o
);
  import mvm_pkg::*;

  logic signed [VAL_W-1:0]  mem [COLS];
  logic signed [VAL_W-1:0]  w_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d, acc_sum;
  logic signed [SUM_W-1:0]  sh_q, sh_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[wr_col_i] <= wr_data_i;
    end
    w_q <= mem[rd_col_i];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= w_q * x_i;
  end

  always_comb begin
    acc_sum = ctrl_i.mac ? acc_q + SUM_W'(prod_q) : acc_q;
    acc_d   = ctrl_i.load ? '0 : acc_sum;
    sh_d    = sh_q;
    if (ctrl_i.load) begin
      sh_d = acc_sum;
    end else if (ctrl_i.shift) begin
      sh_d = sh_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign sh_o = sh_q;

endmodule

// ----- design/matrix_vector_multiply.sv -----
`timescale 1ns / 1ps
// Matrix-vector multiply y = W x, signed Q8.8 operands, Q22.16 sums in 38 bits.
// Input stream (s_axis): tuser = command (weight write or vector element),
// tdata = row_index, col_index, value; tlast marks the final vector element.
// Weight writes and ordinary elements are taken one beat per cycle.
// Each matrix row is one cell holding its row of weights in a local
// memory and its accumulator; an element is broadcast to all cells and the
// multiply-accumulate runs in three steps: read, multiply, add.
// On the final element the input stalls: after its beat passes fin1_q and
// fin2_q every cell loads its sum into a shift chain and the rows leave
// through m_axis, row 0 first, one beat per cycle while m_axis_tready_i is
// high; tlast marks the last active row. The next beat is taken only after
// the last active row has been accepted.
// A stalled receiver simply holds the chain.
// cfg_we_i/cfg_wdata_i write rows_in_use (0 acts as 1, above ROWS as ROWS).
// Reset clears the accumulators and control and sets rows_in_use to 16;
// the weight memories are not cleared and must be written before use.
module matrix_vector_multiply #(
  parameter int unsigned ROWS = mvm_pkg::ROWS_DEF,
  parameter int unsigned COLS = mvm_pkg::COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,      // rows_in_use
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // row_index[3:0], col_index[9:4], value[25:10]
  input  logic        s_axis_tuser_i,   // command[0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // out_row[3:0], row_sum[41:4]
  output logic        m_axis_tlast_o
);
  import mvm_pkg::*;

  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned RI = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NW = $clog2(ROWS + 1);

  logic [CFG_W-1:0] cfg_q;
  logic [NW-1:0]    n_act;
  logic [NW-1:0]    emit_n_q;
  logic [RI-1:0]    cnt_q;
  logic             busy_q, emit_q;
  logic             v1_q, v2_q, fin1_q, fin2_q;
  logic [ROWS-1:0]  act1_q, act2_q, row_act;
  logic signed [VAL_W-1:0] x_q;

  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_val;
  cmd_e                    in_cmd;
  logic                    in_acc, col_ok, out_acc, out_last;

  logic signed [SUM_W-1:0] sh [ROWS+1];

  assign in_row = s_axis_tdata_i[3:0];
  assign in_col = s_axis_tdata_i[9:4];
  assign in_val = s_axis_tdata_i[25:10];
  assign in_cmd = cmd_e'(s_axis_tuser_i);

  assign s_axis_tready_o = !busy_q;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign col_ok  = IDX_W'(in_col) < IDX_W'(COLS);
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign out_last = (NW'(cnt_q) + NW'(1)) == emit_n_q;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = NW'(1);
    end else if (IDX_W'(cfg_q) > IDX_W'(ROWS)) begin
      n_act = NW'(ROWS);
    end else begin
      n_act = NW'(cfg_q);
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_act
    assign row_act[r] = IDX_W'(r) < IDX_W'(n_act);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CFG_W'(16);
      busy_q   <= 1'b0;
      emit_q   <= 1'b0;
      cnt_q    <= '0;
      emit_n_q <= NW'(1);
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      fin1_q   <= 1'b0;
      fin2_q   <= 1'b0;
      act1_q   <= '0;
      act2_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      v1_q   <= in_acc && in_cmd == CMD_ELEMENT && col_ok;
      fin1_q <= in_acc && in_cmd == CMD_ELEMENT && s_axis_tlast_i;
      act1_q <= row_act;
      v2_q   <= v1_q;
      fin2_q <= fin1_q;
      act2_q <= act1_q;
      if (in_acc && in_cmd == CMD_ELEMENT && s_axis_tlast_i) begin
        busy_q   <= 1'b1;
        emit_n_q <= n_act;
      end
      if (fin2_q) begin
        emit_q <= 1'b1;
        cnt_q  <= '0;
      end else if (out_acc) begin
        if (out_last) begin
          emit_q <= 1'b0;
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + RI'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= in_val;
  end

  assign sh[ROWS] = '0;

  for (genvar r = 0; r < ROWS; r++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.wr    = in_acc && in_cmd == CMD_WEIGHT && col_ok
                        && IDX_W'(in_row) == IDX_W'(r);
    assign ctrl.mac   = v2_q && act2_q[r];
    assign ctrl.load  = fin2_q;
    assign ctrl.shift = out_acc;

    mvm_cell #(
      .COLS (COLS),
      .CW   (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_col_i  (in_col[CW-1:0]),
      .rd_col_i  (in_col[CW-1:0]),
      .wr_data_i (in_val),
      .x_i       (x_q),
      .sh_i      (sh[r+1]),
      .sh_o      (sh[r])
    );
  end

  assign m_axis_tvalid_o = emit_q;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tdata_o  = {6'b0, sh[0], ROW_W'(cnt_q)};

  a_emit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> busy_q)
    else $error("emission outside a busy run");

  a_fin_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin2_q |=> emit_q && cnt_q == '0)
    else $error("final element did not start emission");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last) |=> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("emission continued after last row");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> NW'(cnt_q) < emit_n_q)
    else $error("row counter beyond active rows");

endmodule
